### design/dps_pkg.sv
package dps_pkg;

    localparam int MAX_PROCS = 8;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int ID_W      = 3;
    localparam int PRI_W     = 11;
    localparam int TIME_W    = 16;

    localparam logic signed [PRI_W-1:0] PRI_MIN = -11'sd1024;
    localparam logic signed [PRI_W-1:0] FIN_PRI = -11'sd10;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        OUT_RAN      = 2'd0,
        OUT_DONE     = 2'd1,
        OUT_FINISHED = 2'd2,
        OUT_EMPTY    = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [PRI_W-1:0] pri;
        logic [TIME_W-1:0]       need;
        logic [TIME_W-1:0]       run;
        logic                    fin;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   ins;
    } cell_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        outcome_t                outcome;
        logic signed [PRI_W-1:0] pri;
        logic [TIME_W-1:0]       run;
    } result_t;

endpackage

### design/dps_cell.sv
module dps_cell (
    input  logic               clk,
    input  dps_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_gt,
    input  dps_pkg::entry_t    left_entry,
    input  dps_pkg::entry_t    right_entry,
    output dps_pkg::entry_t    entry,
    output logic               gt
);

    dps_pkg::entry_t entry_reg;
    dps_pkg::entry_t entry_next;

    assign gt    = occupied && ($signed(entry_reg.pri) > $signed(cmd.ins.pri));
    assign entry = entry_reg;

    always_comb
    begin
        case (cmd.op)
            dps_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            dps_pkg::CELL_INSERT:
            begin
                if (gt)
                begin
                    entry_next = entry_reg;
                end
                else if (left_gt)
                begin
                    entry_next = cmd.ins;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
            dps_pkg::CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### design/dynamic_priority_scheduler_top.sv
// Dynamic priority scheduler with aging.
// Input channel s_axis: tuser carries the opcode (load or tick), tdata the
// priority and need time of a loaded process. Output channel m_axis gives
// one beat per tick: process id, outcome, priority after and run time.
// The table is a row of cells kept in descending priority order; each cell
// compares its priority with the entry being placed and either holds,
// takes the new entry or takes its left neighbour's entry.
// A load gives no output beat; a load into a full table is dropped. A
// tick first pops the head and ages it, then places it back in the row
// and writes the output register. A tick on an empty table skips the pop
// and place steps and gives a beat with the empty outcome.
// One item is in progress at a time; s_axis_tready is high only when idle.
// When the receiver stalls, a finished result waits in an internal hold
// state until the output register frees, and no new beat is taken then.
// Reset empties the table and clears the output valid; the cell contents
// are not cleared and are read only where occupied.
module dynamic_priority_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // new_priority[10:0], need_time[26:11]
    input  logic [0:0]  s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // proc_id[2:0], priority_after[13:3], run_time[29:14]
    output logic [1:0]  m_axis_tuser    // outcome[1:0]
);

    localparam int N = dps_pkg::MAX_PROCS;

    dps_pkg::state_t                    state_reg, state_next;
    logic [dps_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    dps_pkg::entry_t                    serve_reg, serve_next;
    dps_pkg::result_t                   res_reg, res_next;
    dps_pkg::result_t                   out_reg;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_load;
    logic                               out_free;
    logic                               accept;
    dps_pkg::cell_cmd_t                 cmd;
    dps_pkg::entry_t                    cell_entry [N];
    logic                               cell_gt    [N];
    dps_pkg::entry_t                    head;
    dps_pkg::entry_t                    aged;
    dps_pkg::outcome_t                  aged_outcome;

    assign s_axis_tready = (state_reg == dps_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign head          = cell_entry[0];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            dps_pkg::entry_t left_e;
            dps_pkg::entry_t right_e;
            logic            left_g;
            if (i == 0)
            begin : g_first
                assign left_e = '0;
                assign left_g = 1'b1;
            end
            else
            begin : g_rest
                assign left_e = cell_entry[i-1];
                assign left_g = cell_gt[i-1];
            end
            if (i == N - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[i+1];
            end
            dps_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (dps_pkg::CNT_W'(i) < cnt_reg),
                .left_gt     (left_g),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_entry[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        aged = head;
        if (head.fin)
        begin
            aged_outcome = dps_pkg::OUT_FINISHED;
            aged.pri     = dps_pkg::FIN_PRI;
        end
        else if (head.run < head.need)
        begin
            aged_outcome = dps_pkg::OUT_RAN;
            aged.run     = head.run + 1'b1;
            if (head.pri != dps_pkg::PRI_MIN)
            begin
                aged.pri = head.pri - 1'b1;
            end
        end
        else
        begin
            aged_outcome = dps_pkg::OUT_DONE;
            aged.fin     = 1'b1;
            aged.pri     = dps_pkg::FIN_PRI;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        serve_next = serve_reg;
        res_next   = res_reg;
        out_load   = 1'b0;
        cmd.op     = dps_pkg::CELL_HOLD;
        cmd.ins    = serve_reg;
        case (state_reg)
            dps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (dps_pkg::op_t'(s_axis_tuser[0]) == dps_pkg::OP_LOAD)
                    begin
                        cmd.ins.id   = dps_pkg::ID_W'(cnt_reg);
                        cmd.ins.pri  = $signed(s_axis_tdata[10:0]);
                        cmd.ins.need = s_axis_tdata[26:11];
                        cmd.ins.run  = '0;
                        cmd.ins.fin  = 1'b0;
                        if (cnt_reg < dps_pkg::CNT_W'(N))
                        begin
                            cmd.op   = dps_pkg::CELL_INSERT;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_next.id      = '0;
                        res_next.outcome = dps_pkg::OUT_EMPTY;
                        res_next.pri     = '0;
                        res_next.run     = '0;
                        if (out_free)
                        begin
                            out_load = 1'b1;
                        end
                        else
                        begin
                            state_next = dps_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.op           = dps_pkg::CELL_SHIFT;
                        cnt_next         = cnt_reg - 1'b1;
                        serve_next       = aged;
                        res_next.id      = aged.id;
                        res_next.outcome = aged_outcome;
                        res_next.pri     = aged.pri;
                        res_next.run     = aged.run;
                        state_next       = dps_pkg::ST_INSERT;
                    end
                end
            end
            dps_pkg::ST_INSERT:
            begin
                cmd.op   = dps_pkg::CELL_INSERT;
                cnt_next = cnt_reg + 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = dps_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = dps_pkg::ST_EMIT;
                end
            end
            dps_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = dps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dps_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        serve_reg <= serve_next;
        res_reg   <= res_next;
        if (out_load)
        begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.run, out_reg.pri, out_reg.id};
    assign m_axis_tuser  = out_reg.outcome;

endmodule
